// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the color temperature block.
// Has no dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define CTADJ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define CTADJ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ctadj_pkg.sv =====
// Types and constants of the RGB565 color temperature block.
// No dependencies; used by the channel interfaces and the top level.
package ctadj_pkg;

  localparam int unsigned PixelWidth  = 16;
  localparam int unsigned ChanWidth   = 5;
  localparam int unsigned OffsetWidth = 8;
  localparam int unsigned ScaledWidth = 14;
  localparam int unsigned RecipWidth  = 13;
  localparam int unsigned ProdWidth   = ScaledWidth + RecipWidth;
  localparam int unsigned FactorWidth = 10;
  localparam int unsigned RemWidth    = 13;

  localparam logic signed [OffsetWidth-1:0] OffsetMax = 8'sd100;
  localparam logic signed [OffsetWidth-1:0] OffsetMin = -8'sd100;

  // F = 256 + floor(256*t/100) = floor((6400 + 64*t) / 25); 1/25 is 5243 / 2^17.
  localparam logic [15:0]            ScaledBase = 16'd6400;
  localparam logic [RecipWidth-1:0]  Recip25    = 13'd5243;
  localparam int unsigned            RecipShift = 17;
  localparam logic [FactorWidth:0]   FactorSum  = 11'd512;
  localparam logic [ChanWidth-1:0]   ChanMax    = 5'd31;

  typedef logic [PixelWidth-1:0] pixel_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_WARM,
    MODE_COOL
  } mode_e;

endpackage

// ===== hw/rtl/ctadj_in_if.sv =====
// Input pixel channel of the color temperature block.
// Depends on ctadj_pkg for the pixel type.
interface ctadj_in_if
  import ctadj_pkg::*;
();
  logic   valid;
  logic   ready;
  pixel_t pixel_in;
  logic   frame_end_in;

  modport source (output valid, output pixel_in, output frame_end_in, input ready);
  modport sink (input valid, input pixel_in, input frame_end_in, output ready);
endinterface

// ===== hw/rtl/ctadj_out_if.sv =====
// Output pixel channel of the color temperature block.
// Depends on ctadj_pkg for the pixel type.
interface ctadj_out_if
  import ctadj_pkg::*;
();
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   frame_end_out;

  modport source (output valid, output pixel_out, output frame_end_out, input ready);
  modport sink (input valid, input pixel_out, input frame_end_out, output ready);
endinterface

// ===== hw/rtl/rgb565_color_temperature_adjust.sv =====
// Channel   Direction  Payload                       Beat taken when
// in_i      sink       pixel_in[15:0], frame_end_in  valid && ready
// out_o     source     pixel_out[15:0], frame_end_out valid && ready
// cfg       write      cfg_wdata_i[7:0] (offset)     cfg_we_i
//
// Four register stages: offset clamp and factor multiply, channel multiply and divider
// setup, three quotient bits, the last two quotient bits into the output register.
// A beat is accepted every cycle unless out_o stalls; out_o.valid is the stage 4 valid bit.
// Each stage holds its beat while the stage after it is full and stalled, so bubbles close up.
// Reset clears the stage valid bits and sets the offset to zero; data registers are not reset.
// Depends on ctadj_pkg, ctadj_in_if, ctadj_out_if and assert_macros.svh.
`include "assert_macros.svh"

module rgb565_color_temperature_adjust
  import ctadj_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  ctadj_in_if.sink               in_i,
  ctadj_out_if.source            out_o,
  input  logic                   cfg_we_i,
  input  logic [OffsetWidth-1:0] cfg_wdata_i
);

  logic signed [OffsetWidth-1:0] offset_q;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // Stage 1
  logic signed [OffsetWidth-1:0] t_clamped;
  logic [15:0]                   scaled_full;
  logic [ProdWidth-1:0]          s1_prod_d, s1_prod_q;
  mode_e                         s1_mode_d, s1_mode_q;
  pixel_t                        s1_pix_q;
  logic                          s1_fe_q;

  // Stage 2
  logic [FactorWidth-1:0]   factor_f, factor_g, mul_factor;
  logic [ChanWidth-1:0]     mul_chan, div_chan;
  logic [ChanWidth+FactorWidth-1:0] chan_prod;
  logic [ChanWidth-1:0]     s2_mul_d, s2_mul_q;
  logic [FactorWidth-1:0]   s2_div_d, s2_div_q;
  logic [RemWidth-1:0]      s2_rem_d, s2_rem_q;
  mode_e                    s2_mode_q;
  pixel_t                   s2_pix_q;
  logic                     s2_fe_q;

  // Stage 3
  logic [RemWidth:0]        trial3;
  logic [RemWidth-1:0]      s3_rem_d, s3_rem_q;
  logic [2:0]               s3_quo_d, s3_quo_q;
  logic [ChanWidth-1:0]     s3_mul_q;
  logic [FactorWidth-1:0]   s3_div_q;
  mode_e                    s3_mode_q;
  pixel_t                   s3_pix_q;
  logic                     s3_fe_q;

  // Stage 4
  logic [RemWidth:0]        trial4;
  logic [RemWidth-1:0]      rem4;
  logic [1:0]               quo_low;
  logic [ChanWidth-1:0]     quotient;
  logic [ChanWidth-1:0]     red_new, blue_new;
  pixel_t                   s4_pix_d, s4_pix_q;
  logic                     s4_fe_q;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (en1) begin
        v1_q <= in_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_comb begin
    if (offset_q > OffsetMax) begin
      t_clamped = OffsetMax;
    end else if (offset_q < OffsetMin) begin
      t_clamped = OffsetMin;
    end else begin
      t_clamped = offset_q;
    end
    scaled_full = ScaledBase + {{2{t_clamped[OffsetWidth-1]}}, t_clamped, 6'b0};
    s1_prod_d   = ProdWidth'(scaled_full[ScaledWidth-1:0]) * ProdWidth'(Recip25);
    if (t_clamped > 8'sd0) begin
      s1_mode_d = MODE_WARM;
    end else if (t_clamped < 8'sd0) begin
      s1_mode_d = MODE_COOL;
    end else begin
      s1_mode_d = MODE_PASS;
    end
  end

  always_comb begin
    factor_f = s1_prod_q[RecipShift +: FactorWidth];
    factor_g = FactorWidth'(FactorSum - {1'b0, factor_f});
    if (s1_mode_q == MODE_WARM) begin
      mul_chan   = s1_pix_q[15:11];
      mul_factor = factor_f;
      div_chan   = s1_pix_q[4:0];
    end else begin
      mul_chan   = s1_pix_q[4:0];
      mul_factor = factor_g;
      div_chan   = s1_pix_q[15:11];
    end
    chan_prod = (ChanWidth + FactorWidth)'(mul_chan) * (ChanWidth + FactorWidth)'(mul_factor);
    if (chan_prod[ChanWidth+FactorWidth-1:8] > 7'(ChanMax)) begin
      s2_mul_d = ChanMax;
    end else begin
      s2_mul_d = chan_prod[8 +: ChanWidth];
    end
    s2_div_d = mul_factor;
    s2_rem_d = {div_chan, 8'b0};
  end

  always_comb begin
    s3_rem_d = s2_rem_q;
    s3_quo_d = '0;
    trial3   = '0;
    for (int k = 0; k < 3; k++) begin
      trial3 = (RemWidth + 1)'(s2_div_q) << (4 - k);
      if ({1'b0, s3_rem_d} >= trial3) begin
        s3_rem_d       = s3_rem_d - trial3[RemWidth-1:0];
        s3_quo_d[2-k]  = 1'b1;
      end
    end
  end

  always_comb begin
    rem4    = s3_rem_q;
    quo_low = '0;
    trial4  = '0;
    for (int k = 0; k < 2; k++) begin
      trial4 = (RemWidth + 1)'(s3_div_q) << (1 - k);
      if ({1'b0, rem4} >= trial4) begin
        rem4         = rem4 - trial4[RemWidth-1:0];
        quo_low[1-k] = 1'b1;
      end
    end
    quotient = {s3_quo_q, quo_low};
    case (s3_mode_q)
      MODE_WARM: begin
        red_new  = s3_mul_q;
        blue_new = quotient;
      end
      MODE_COOL: begin
        red_new  = quotient;
        blue_new = s3_mul_q;
      end
      default: begin
        red_new  = s3_pix_q[15:11];
        blue_new = s3_pix_q[4:0];
      end
    endcase
    s4_pix_d = {red_new, s3_pix_q[10:5], blue_new};
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      s1_prod_q <= s1_prod_d;
      s1_mode_q <= s1_mode_d;
      s1_pix_q  <= in_i.pixel_in;
      s1_fe_q   <= in_i.frame_end_in;
    end
    if (en2 && v1_q) begin
      s2_mul_q  <= s2_mul_d;
      s2_div_q  <= s2_div_d;
      s2_rem_q  <= s2_rem_d;
      s2_mode_q <= s1_mode_q;
      s2_pix_q  <= s1_pix_q;
      s2_fe_q   <= s1_fe_q;
    end
    if (en3 && v2_q) begin
      s3_rem_q  <= s3_rem_d;
      s3_quo_q  <= s3_quo_d;
      s3_mul_q  <= s2_mul_q;
      s3_div_q  <= s2_div_q;
      s3_mode_q <= s2_mode_q;
      s3_pix_q  <= s2_pix_q;
      s3_fe_q   <= s2_fe_q;
    end
    if (en4 && v3_q) begin
      s4_pix_q <= s4_pix_d;
      s4_fe_q  <= s3_fe_q;
    end
  end

  assign out_o.valid         = v4_q;
  assign out_o.pixel_out     = s4_pix_q;
  assign out_o.frame_end_out = s4_fe_q;

  // The divisor of a warm or cool beat is at least 256, so five quotient bits suffice.
  `CTADJ_ASSERT(a_div_range, clk_i, rst_ni, (v2_q && s2_mode_q != MODE_PASS) |-> (s2_div_q >= 10'd256), "divisor below 256")
  // After three quotient bits the partial remainder is below four divisors.
  `CTADJ_ASSERT(a_rem_bound, clk_i, rst_ni, v3_q |-> ({1'b0, s3_rem_q} < {s3_div_q, 2'b0}), "remainder out of range")
  // A beat in pass mode leaves the last stage unchanged.
  `CTADJ_ASSERT(a_pass_through, clk_i, rst_ni, (v3_q && en4 && s3_mode_q == MODE_PASS) |=> (out_o.pixel_out == $past(s3_pix_q)), "pass beat altered")

endmodule
